[hdl/grg_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// grg_pkg: shared types and constants of the gradient ramp generator
// Opcodes, stop entry layout, the controller/datapath command and status
// words, and the divide-by-255 helper used for premultiplication.
// ----------------------------------------------------------------------------
package grg_pkg;

	// input word opcodes
	localparam logic [1:0] OP_CLEAR  = 2'd0;
	localparam logic [1:0] OP_APPEND = 2'd1;
	localparam logic [1:0] OP_LOOKUP = 2'd2;

	// reset value of the global alpha register
	localparam logic [7:0] ALPHA_RESET = 8'hFF;

	// stand-in stops of an empty list: black at 0, white at 255
	localparam logic [7:0]  EMPTY_OFF_LO = 8'd0;
	localparam logic [23:0] EMPTY_RGB_LO = 24'h000000;
	localparam logic [7:0]  EMPTY_OFF_HI = 8'd255;
	localparam logic [23:0] EMPTY_RGB_HI = 24'hFFFFFF;

	// steps of the restoring divider (16-bit dividend)
	localparam int DIV_STEPS = 16;

	typedef struct packed {
		logic [7:0]  offset;
		logic [23:0] rgb;
	} stop_t;

	// controller -> datapath
	typedef struct packed {
		logic clear;   // empty the stop list
		logic append;  // write a stop
		logic start;   // capture lookup index, arm the scan
		logic scan;    // walk the stop list
		logic fetch0;  // read the winning stop
		logic fetch1;  // latch it, read the next stop
		logic latch1;  // latch the next stop
		logic mul;     // channel delta times distance
		logic div;     // one divider step
		logic add;     // start color plus quotient
		logic pmul;    // channel times alpha
		logic emit;    // load the output register
	} grg_cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic scan_done;
		logic div_done;
		logic win_lerp;
		logic out_free;
	} grg_stat_t;

	// floor(y / 255) for y <= 255 * 255
	function automatic logic [7:0] div255(input logic [15:0] y);
		logic [16:0] s;
		s = {1'b0, y} + {9'd0, y[15:8]} + 17'd1;
		return s[15:8];
	endfunction

endpackage
`default_nettype wire

[hdl/grg_in_if.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// grg_in_if: command channel of the gradient ramp generator
// Valid/ready channel carrying one opcode, position and stop color per word.
// ----------------------------------------------------------------------------
interface grg_in_if;
	logic        valid;
	logic        ready;
	logic [1:0]  operation;
	logic [7:0]  position;
	logic [23:0] stop_rgb;

	modport source (output valid, output operation, output position, output stop_rgb,
		input ready);
	modport sink (input valid, input operation, input position, input stop_rgb,
		output ready);
endinterface
`default_nettype wire

[hdl/grg_out_if.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// grg_out_if: result channel of the gradient ramp generator
// Valid/ready channel carrying one premultiplied ARGB ramp entry per word.
// ----------------------------------------------------------------------------
interface grg_out_if;
	logic        valid;
	logic        ready;
	logic [31:0] ramp_pixel;
	logic [7:0]  ramp_index;

	modport source (output valid, output ramp_pixel, output ramp_index, input ready);
	modport sink (input valid, input ramp_pixel, input ramp_index, output ready);
endinterface
`default_nettype wire

[hdl/gradient_ramp_generator.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// gradient_ramp_generator: premultiplied linear gradient color ramp
// Holds up to MAX_STOPS gradient stops and answers lookups of the 256-entry
// ramp with premultiplied ARGB8888 entries.
// ----------------------------------------------------------------------------
// A clear or append word is taken straight from idle. A lookup walks the stop
// list through the single read port of the stop memory, one stop per cycle
// (both stand-in stops for an empty list). A flat color then goes straight
// to premultiply; an interpolated one first passes through the 16-step
// divider, one lane per color channel. The next word is taken as soon as the
// result sits in the output register.
// ----------------------------------------------------------------------------
module gradient_ramp_generator
	import grg_pkg::*;
#(
	parameter int MAX_STOPS = 16
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       cfg_we,
	input  wire logic [7:0] cfg_wdata,
	grg_in_if.sink          cmd,
	grg_out_if.source       ramp
);

	grg_cmd_t  ctl;
	grg_stat_t stat;

	grg_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (cmd.valid),
		.in_op    (cmd.operation),
		.in_ready (cmd.ready),
		.stat     (stat),
		.ctl      (ctl)
	);

	grg_datapath #(
		.MAX_STOPS (MAX_STOPS)
	) u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.position  (cmd.position),
		.stop_rgb  (cmd.stop_rgb),
		.ctl       (ctl),
		.stat      (stat),
		.out_ready (ramp.ready),
		.out_valid (ramp.valid),
		.out_pixel (ramp.ramp_pixel),
		.out_index (ramp.ramp_index)
	);

endmodule
`default_nettype wire

[hdl/grg_ctrl.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// grg_ctrl: sequencer of the gradient ramp generator
// One-hot state machine that takes input words and steps the datapath
// through scan, fetch, interpolate, premultiply and emit.
// ----------------------------------------------------------------------------
module grg_ctrl
	import grg_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	input  wire logic [1:0] in_op,
	output logic            in_ready,
	input  grg_stat_t       stat,
	output grg_cmd_t        ctl
);

	typedef enum logic [9:0] {
		ST_IDLE   = 10'b00_0000_0001,
		ST_SCAN   = 10'b00_0000_0010,
		ST_FETCH0 = 10'b00_0000_0100,
		ST_FETCH1 = 10'b00_0000_1000,
		ST_FETCH2 = 10'b00_0001_0000,
		ST_MUL    = 10'b00_0010_0000,
		ST_DIV    = 10'b00_0100_0000,
		ST_ADD    = 10'b00_1000_0000,
		ST_PMUL   = 10'b01_0000_0000,
		ST_EMIT   = 10'b10_0000_0000
	} state_t;

	state_t state_q, state_d;

	// next state and commands
	always_comb begin
		state_d  = state_q;
		ctl      = '0;
		in_ready = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					case (in_op)
						OP_CLEAR:  ctl.clear  = 1'b1;
						OP_APPEND: ctl.append = 1'b1;
						OP_LOOKUP: begin
							ctl.start = 1'b1;
							state_d   = ST_SCAN;
						end
						default: ;
					endcase
				end
			end
			ST_SCAN: begin
				ctl.scan = 1'b1;
				if (stat.scan_done) state_d = ST_FETCH0;
			end
			ST_FETCH0: begin
				ctl.fetch0 = 1'b1;
				state_d    = ST_FETCH1;
			end
			ST_FETCH1: begin
				ctl.fetch1 = 1'b1;
				state_d    = stat.win_lerp ? ST_FETCH2 : ST_PMUL;
			end
			ST_FETCH2: begin
				ctl.latch1 = 1'b1;
				state_d    = ST_MUL;
			end
			ST_MUL: begin
				ctl.mul = 1'b1;
				state_d = ST_DIV;
			end
			ST_DIV: begin
				ctl.div = 1'b1;
				if (stat.div_done) state_d = ST_ADD;
			end
			ST_ADD: begin
				ctl.add = 1'b1;
				state_d = ST_PMUL;
			end
			ST_PMUL: begin
				ctl.pmul = 1'b1;
				state_d  = ST_EMIT;
			end
			ST_EMIT: begin
				if (stat.out_free) begin
					ctl.emit = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= ST_IDLE;
		else         state_q <= state_d;
	end

endmodule
`default_nettype wire

[hdl/grg_datapath.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// grg_datapath: storage and arithmetic of the gradient ramp generator
// Stop memory, segment search, three-lane restoring divider, alpha
// premultiply and the output register.
// ----------------------------------------------------------------------------
module grg_datapath
	import grg_pkg::*;
#(
	parameter int MAX_STOPS = 16
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_we,
	input  wire logic [7:0]  cfg_wdata,
	input  wire logic [7:0]  position,
	input  wire logic [23:0] stop_rgb,
	input  grg_cmd_t         ctl,
	output grg_stat_t        stat,
	input  wire logic        out_ready,
	output logic             out_valid,
	output logic [31:0]      out_pixel,
	output logic [7:0]       out_index
);

	localparam int AW = $clog2(MAX_STOPS);
	localparam int CW = $clog2(MAX_STOPS + 1);
	localparam int DCW = $clog2(DIV_STEPS);

	// configuration
	logic [7:0] alpha_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)     alpha_q <= ALPHA_RESET;
		else if (cfg_we) alpha_q <= cfg_wdata;
	end

	// stop count
	logic [CW-1:0] total_q;
	logic [CW-1:0] total_m1;
	logic          full;

	assign full     = (total_q == CW'(MAX_STOPS));
	assign total_m1 = total_q - CW'(1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)                   total_q <= '0;
		else if (ctl.clear)            total_q <= '0;
		else if (ctl.append && !full)  total_q <= total_q + CW'(1);
	end

	// scan control
	logic [7:0]    idx_q;
	logic          empty_q;
	logic [AW-1:0] last_q;
	logic [AW-1:0] k_q;
	logic          iss_q;
	logic          issue;

	assign issue = ctl.scan && iss_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			iss_q <= 1'b0;
			k_q   <= '0;
		end else if (ctl.start) begin
			iss_q <= 1'b1;
			k_q   <= '0;
		end else if (issue) begin
			k_q <= k_q + AW'(1);
			if (k_q == last_q) iss_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.start) begin
			idx_q   <= position;
			empty_q <= (total_q == '0);
			last_q  <= (total_q == '0) ? AW'(1) : total_m1[AW-1:0];
		end
	end

	// stop memory, one write and one registered read
	stop_t         stop_mem [MAX_STOPS];
	stop_t         rd_q;
	logic [AW-1:0] rd_addr;
	logic [AW-1:0] rd_addr_s1;
	logic          rd_en;
	logic          rd_vld_s1;
	logic          win_valid_q;
	logic          win_lerp_q;
	logic [AW-1:0] win_idx_q;

	always_comb begin
		if (issue)           rd_addr = k_q;
		else if (ctl.fetch0) rd_addr = win_idx_q;
		else                 rd_addr = win_idx_q + AW'(1);
	end

	assign rd_en = issue || ctl.fetch0 || (ctl.fetch1 && win_lerp_q);

	always_ff @(posedge clk) begin
		if (ctl.append && !full) stop_mem[total_q[AW-1:0]] <= '{offset: position, rgb: stop_rgb};
		if (rd_en) begin
			rd_q       <= stop_mem[rd_addr];
			rd_addr_s1 <= rd_addr;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) rd_vld_s1 <= 1'b0;
		else         rd_vld_s1 <= issue;
	end

	// entry as seen by the search: stand-in ramp when the list is empty
	stop_t entry;

	always_comb begin
		if (!empty_q)               entry = rd_q;
		else if (rd_addr_s1 == '0)  entry = '{offset: EMPTY_OFF_LO, rgb: EMPTY_RGB_LO};
		else                        entry = '{offset: EMPTY_OFF_HI, rgb: EMPTY_RGB_HI};
	end

	// segment search, last matching rule wins
	logic [7:0] prev_q;
	logic       hit_first, hit_eq, hit_in, hit_fin, eval;

	assign eval      = ctl.scan && rd_vld_s1;
	assign hit_first = (rd_addr_s1 == '0) && (idx_q < entry.offset);
	assign hit_eq    = (rd_addr_s1 != '0) && (idx_q == prev_q);
	assign hit_in    = (rd_addr_s1 != '0) && (prev_q < idx_q) && (idx_q < entry.offset);
	assign hit_fin   = (rd_addr_s1 == last_q) && (idx_q >= entry.offset);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_valid_q <= 1'b0;
			win_lerp_q  <= 1'b0;
			win_idx_q   <= '0;
		end else if (ctl.start) begin
			win_valid_q <= 1'b0;
			win_lerp_q  <= 1'b0;
			win_idx_q   <= '0;
		end else if (eval) begin
			if (hit_fin) begin
				win_valid_q <= 1'b1;
				win_lerp_q  <= 1'b0;
				win_idx_q   <= rd_addr_s1;
			end else if (hit_in) begin
				win_valid_q <= 1'b1;
				win_lerp_q  <= 1'b1;
				win_idx_q   <= rd_addr_s1 - AW'(1);
			end else if (hit_eq) begin
				win_valid_q <= 1'b1;
				win_lerp_q  <= 1'b0;
				win_idx_q   <= rd_addr_s1 - AW'(1);
			end else if (hit_first) begin
				win_valid_q <= 1'b1;
				win_lerp_q  <= 1'b0;
				win_idx_q   <= '0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (eval) prev_q <= entry.offset;
	end

	assign stat.scan_done = rd_vld_s1 && (rd_addr_s1 == last_q);
	assign stat.win_lerp  = win_lerp_q;

	// segment end points
	logic [7:0]      off0_q, off1_q;
	logic [2:0][7:0] col0_q, col1_q;

	always_ff @(posedge clk) begin
		if (ctl.fetch1) begin
			off0_q <= entry.offset;
			col0_q <= entry.rgb;
		end
		if (ctl.latch1) begin
			off1_q <= entry.offset;
			col1_q <= entry.rgb;
		end
	end

	// delta times distance, split into sign and magnitude
	logic [7:0]              seg_pos;
	logic signed [2:0][8:0]  delta;
	logic signed [2:0][17:0] prod;
	logic [2:0][15:0]        prod_mag;

	assign seg_pos = idx_q - off0_q;

	always_comb begin
		for (int c = 0; c < 3; c++) begin
			delta[c]    = $signed({1'b0, col1_q[c]}) - $signed({1'b0, col0_q[c]});
			prod[c]     = $signed(delta[c]) * $signed({1'b0, seg_pos});
			prod_mag[c] = prod[c][17] ? 16'(-prod[c]) : prod[c][15:0];
		end
	end

	// restoring divider, three lanes, one quotient bit per cycle
	logic [7:0]       ds_q;
	logic [2:0]       neg_q;
	logic [2:0][15:0] num_q;
	logic [2:0][7:0]  rem_q;
	logic [2:0][7:0]  quo_q;
	logic [DCW-1:0]   div_cnt_q;
	logic [2:0][8:0]  trial;
	logic [2:0]       ge;

	always_comb begin
		for (int c = 0; c < 3; c++) begin
			trial[c] = {rem_q[c], num_q[c][15]};
			ge[c]    = (trial[c] >= {1'b0, ds_q});
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.mul) begin
			ds_q <= off1_q - off0_q;
			for (int c = 0; c < 3; c++) begin
				neg_q[c] <= prod[c][17];
				num_q[c] <= prod_mag[c];
				rem_q[c] <= '0;
				quo_q[c] <= '0;
			end
		end else if (ctl.div) begin
			for (int c = 0; c < 3; c++) begin
				rem_q[c] <= ge[c] ? 8'(trial[c] - {1'b0, ds_q}) : trial[c][7:0];
				num_q[c] <= {num_q[c][14:0], 1'b0};
				quo_q[c] <= {quo_q[c][6:0], ge[c]};
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)      div_cnt_q <= '0;
		else if (ctl.mul) div_cnt_q <= '0;
		else if (ctl.div) div_cnt_q <= div_cnt_q + DCW'(1);
	end

	assign stat.div_done = (div_cnt_q == DCW'(DIV_STEPS - 1));

	// channel value: stop color, or start color plus signed quotient
	logic [2:0][7:0]  chan_q;
	logic [2:0][15:0] pm_q;

	always_ff @(posedge clk) begin
		if (ctl.fetch1) begin
			chan_q <= entry.rgb;
		end else if (ctl.add) begin
			for (int c = 0; c < 3; c++)
				chan_q[c] <= neg_q[c] ? col0_q[c] - quo_q[c] : col0_q[c] + quo_q[c];
		end
		if (ctl.pmul) begin
			for (int c = 0; c < 3; c++)
				pm_q[c] <= chan_q[c] * alpha_q;
		end
	end

	// output register
	logic        out_valid_q;
	logic [31:0] out_pixel_q;
	logic [7:0]  out_index_q;

	assign stat.out_free = !out_valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)        out_valid_q <= 1'b0;
		else if (ctl.emit)  out_valid_q <= 1'b1;
		else if (out_ready) out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (ctl.emit) begin
			out_index_q <= idx_q;
			out_pixel_q <= win_valid_q ?
				{alpha_q, div255(pm_q[2]), div255(pm_q[1]), div255(pm_q[0])} : '0;
		end
	end

	assign out_valid = out_valid_q;
	assign out_pixel = out_pixel_q;
	assign out_index = out_index_q;

endmodule
`default_nettype wire

[verif/tb.sv]
// ----------------------------------------------------------------------------
// tb: self-checking bench for gradient_ramp_generator
// Feeds clear, append and lookup words into the command channel and checks
// every ramp word against an in-bench model of the stop list and the
// premultiplied ramp. A short directed table comes first, then random stop
// lists with lookups. The sender and receiver idle at random, the alpha
// register is rewritten between phases, and one long receiver stall fills
// up the block.
// ----------------------------------------------------------------------------
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	import grg_pkg::*;

	localparam int CLK_PERIOD    = 20;
	localparam int STOP_CAP      = 16;
	localparam int SETTLE_CYCLES = 64;   // margin after the last owed word has come out
	localparam int HOLD_CYCLES   = 400;
	localparam int SEG_ITEMS     = 305;
	localparam int SEG_COUNT     = 6;

	// opcode the block ignores
	localparam logic [1:0] OP_NONE = 2'd3;

	typedef struct packed {
		logic [31:0] pixel;
		logic [7:0]  index;
	} ramp_word_t;

	typedef struct packed {
		logic [1:0]  op;
		logic [7:0]  pos;
		logic [23:0] rgb;
		logic        fixed;
		logic [31:0] fixed_px;
	} dir_row_t;

	logic       clk = 1'b0;
	logic       arst_n;
	logic       cfg_we;
	logic [7:0] cfg_wdata;
	logic       hold_on = 1'b0;
	event       hold_start;

	int src_idle_pct;
	int sink_idle_pct;
	int fail_count = 0;

	// model state of the block
	logic [7:0]  stop_ofs [STOP_CAP];
	logic [23:0] stop_col [STOP_CAP];
	logic [4:0]  stop_cnt;
	logic [7:0]  alpha_q;

	// ramp words still owed by the block, oldest first
	ramp_word_t pending_ramp [$];

	// directed words; fixed rows carry a pixel read straight off the stops
	dir_row_t dir_rows [0:22] = '{
		'{OP_LOOKUP, 8'd0,   24'h000000, 1'b1, 32'hFF000000},  // empty list, black end
		'{OP_LOOKUP, 8'd255, 24'hFFFFFF, 1'b1, 32'hFFFFFFFF},  // empty list, white end
		'{OP_LOOKUP, 8'd128, 24'h000000, 1'b1, 32'hFF808080},
		'{OP_NONE,   8'd255, 24'hFFFFFF, 1'b0, 32'h0},         // ignored opcode
		'{OP_APPEND, 8'd0,   24'hFF0000, 1'b0, 32'h0},
		'{OP_APPEND, 8'd255, 24'h0000FF, 1'b0, 32'h0},
		'{OP_LOOKUP, 8'd0,   24'h000000, 1'b1, 32'hFFFF0000},
		'{OP_LOOKUP, 8'd255, 24'h000000, 1'b1, 32'hFF0000FF},
		'{OP_LOOKUP, 8'd77,  24'h000000, 1'b0, 32'h0},
		'{OP_CLEAR,  8'd0,   24'h000000, 1'b0, 32'h0},
		'{OP_APPEND, 8'd10,  24'hFFFFFF, 1'b0, 32'h0},
		'{OP_APPEND, 8'd17,  24'h000000, 1'b0, 32'h0},         // falling channels
		'{OP_APPEND, 8'd17,  24'h00FF00, 1'b0, 32'h0},         // same offset, later wins
		'{OP_APPEND, 8'd200, 24'h123456, 1'b0, 32'h0},
		'{OP_APPEND, 8'd50,  24'hABCDEF, 1'b0, 32'h0},         // offset goes back down
		'{OP_LOOKUP, 8'd5,   24'h000000, 1'b1, 32'hFFFFFFFF},  // ahead of first stop
		'{OP_LOOKUP, 8'd11,  24'h000000, 1'b0, 32'h0},         // negative delta, trunc
		'{OP_LOOKUP, 8'd17,  24'h000000, 1'b0, 32'h0},
		'{OP_LOOKUP, 8'd100, 24'h000000, 1'b0, 32'h0},
		'{OP_LOOKUP, 8'd255, 24'h000000, 1'b1, 32'hFFABCDEF},  // past last stop
		'{OP_LOOKUP, 8'd30,  24'h000000, 1'b0, 32'h0},
		'{OP_CLEAR,  8'd0,   24'h000000, 1'b0, 32'h0},
		'{OP_LOOKUP, 8'd200, 24'h000000, 1'b1, 32'hFFC8C8C8}
	};

	grg_in_if  cmd_if ();
	grg_out_if ramp_if ();

	gradient_ramp_generator #(
		.MAX_STOPS(STOP_CAP)
	) i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_wdata(cfg_wdata),
		.cmd      (cmd_if),
		.ramp     (ramp_if)
	);

	always #(CLK_PERIOD / 2) clk = ~clk;

	// premultiply one RGB color by the current alpha, alpha in the top byte
	function automatic logic [31:0] shade(input logic [23:0] rgb);
		int r, g, b;
		r = int'(rgb[23:16]) * int'(alpha_q) / 255;
		g = int'(rgb[15:8]) * int'(alpha_q) / 255;
		b = int'(rgb[7:0]) * int'(alpha_q) / 255;
		return {alpha_q, 8'(r), 8'(g), 8'(b)};
	endfunction

	// one channel along a segment; signed division truncates toward zero
	function automatic logic [7:0] blend(input logic [7:0] c0, input logic [7:0] c1,
		input int j, input int ds);
		int d;
		d = (int'(c1) - int'(c0)) * j / ds;
		return 8'(int'(c0) + d);
	endfunction

	// ramp entry at idx, built in write order: leading span, segments, tail
	function automatic logic [31:0] ramp_entry(input logic [7:0] idx);
		logic [7:0]  ofs [STOP_CAP];
		logic [23:0] col [STOP_CAP];
		logic [31:0] px;
		int n, s0, ds, k;
		n = int'(stop_cnt);
		for (int i = 0; i < STOP_CAP; i++) begin
			ofs[i] = stop_ofs[i];
			col[i] = stop_col[i];
		end
		if (n == 0) begin
			ofs[0] = EMPTY_OFF_LO;
			col[0] = EMPTY_RGB_LO;
			ofs[1] = EMPTY_OFF_HI;
			col[1] = EMPTY_RGB_HI;
			n = 2;
		end
		px = '0;
		k = int'(idx);
		if (idx < ofs[0])
			px = shade(col[0]);
		for (int i = 0; i + 1 < n; i++) begin
			s0 = int'(ofs[i]);
			ds = int'(ofs[i + 1]) - s0;
			if (k == s0)
				px = shade(col[i]);
			if (ds > 1 && k > s0 && k < s0 + ds) begin
				px = shade({blend(col[i][23:16], col[i + 1][23:16], k - s0, ds),
					blend(col[i][15:8], col[i + 1][15:8], k - s0, ds),
					blend(col[i][7:0], col[i + 1][7:0], k - s0, ds)});
			end
		end
		if (idx >= ofs[n - 1])
			px = shade(col[n - 1]);
		return px;
	endfunction

	// random stop color, extremes now and then
	function automatic logic [23:0] pick_rgb();
		int sel;
		sel = $urandom_range(7);
		if (sel == 0)
			return 24'h000000;
		else if (sel == 1)
			return 24'hFFFFFF;
		return 24'($urandom);
	endfunction

	// offer one word, wait for it to be taken, then update the model
	task automatic send_word(input logic [1:0] op, input logic [7:0] pos,
		input logic [23:0] rgb, input logic fixed, input logic [31:0] fixed_px);
		while ($urandom_range(99) < src_idle_pct) begin
			cmd_if.valid <= 1'b0;
			@(posedge clk);
		end
		cmd_if.valid     <= 1'b1;
		cmd_if.operation <= op;
		cmd_if.position  <= pos;
		cmd_if.stop_rgb  <= rgb;
		do
			@(posedge clk);
		while (!cmd_if.ready);
		case (op)
			OP_CLEAR: begin
				stop_cnt = '0;
			end
			OP_APPEND: begin
				if (stop_cnt < STOP_CAP) begin
					stop_ofs[stop_cnt] = pos;
					stop_col[stop_cnt] = rgb;
					stop_cnt++;
				end
			end
			OP_LOOKUP: begin
				pending_ramp.push_back('{fixed ? fixed_px : ramp_entry(pos), pos});
			end
			default: begin
			end
		endcase
	endtask

	// stop offering and let every owed word come out
	task automatic drain();
		cmd_if.valid <= 1'b0;
		while (pending_ramp.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_alpha(input logic [7:0] value);
		cfg_we    <= 1'b1;
		cfg_wdata <= value;
		@(posedge clk);
		alpha_q = value;
		cfg_we  <= 1'b0;
	endtask

	// random stop lists followed by lookups, with some noise and broken lists
	task automatic run_segment(input int budget);
		logic [7:0] offs [$];
		logic [7:0] pos;
		logic [1:0] op;
		int sent, seq_no, n_stops, n_look, mode, sel;
		sent = 0;
		seq_no = 0;
		while (sent < budget) begin
			if ($urandom_range(9) == 0) begin
				op = 2'($urandom_range(3));
				send_word(op, 8'($urandom_range(255)), pick_rgb(), 1'b0, 32'h0);
				if (op != OP_NONE)
					sent++;
				continue;
			end
			if (seq_no % 8 == 0)
				n_stops = $urandom_range(STOP_CAP + 4, STOP_CAP);
			else if ($urandom_range(9) == 0)
				n_stops = 0;
			else
				n_stops = $urandom_range(8, 1);
			mode = $urandom_range(9);
			offs.delete();
			for (int i = 0; i < n_stops; i++) begin
				if (mode == 0)
					offs.push_back(8'($urandom_range(3) * 85));
				else
					offs.push_back(8'($urandom_range(255)));
			end
			if (mode > 2)
				offs.sort();
			// now and then the clear is left out and the list grows on
			if ($urandom_range(19) != 0) begin
				send_word(OP_CLEAR, 8'($urandom_range(255)), pick_rgb(), 1'b0, 32'h0);
				sent++;
			end
			foreach (offs[i]) begin
				send_word(OP_APPEND, offs[i], pick_rgb(), 1'b0, 32'h0);
				sent++;
			end
			n_look = $urandom_range(12, 2);
			repeat (n_look) begin
				sel = $urandom_range(7);
				if (sel == 0)
					pos = 8'd0;
				else if (sel == 1)
					pos = 8'd255;
				else if (sel < 4 && offs.size() > 0)
					pos = offs[$urandom_range(offs.size() - 1)] + 8'($urandom_range(2)) - 8'd1;
				else
					pos = 8'($urandom_range(255));
				send_word(OP_LOOKUP, pos, pick_rgb(), 1'b0, 32'h0);
				sent++;
			end
			seq_no++;
		end
	endtask

	// receiver: random stalls, plus the long hold-off
	always @(posedge clk)
		ramp_if.ready <= arst_n && !hold_on && ($urandom_range(99) >= sink_idle_pct);

	initial begin
		forever begin
			@hold_start;
			hold_on <= 1'b1;
			repeat (HOLD_CYCLES) @(posedge clk);
			hold_on <= 1'b0;
		end
	end

	// compare each ramp word with the oldest owed one
	always @(posedge clk) begin
		ramp_word_t want;
		if (arst_n && ramp_if.valid && ramp_if.ready) begin
			if (pending_ramp.size() == 0) begin
				$display("%0t: unexpected ramp word pixel %h index %h", $time,
					ramp_if.ramp_pixel, ramp_if.ramp_index);
				fail_count++;
			end else begin
				want = pending_ramp.pop_front();
				if (ramp_if.ramp_pixel !== want.pixel) begin
					$display("%0t: ramp_pixel expected %h actual %h (index %0d)", $time,
						want.pixel, ramp_if.ramp_pixel, want.index);
					fail_count++;
				end
				if (ramp_if.ramp_index !== want.index) begin
					$display("%0t: ramp_index expected %h actual %h", $time,
						want.index, ramp_if.ramp_index);
					fail_count++;
				end
			end
		end
	end

	initial begin
		#15ms;
		$display("Test completed with failures");
		$finish;
	end

	initial begin
		logic [7:0] alpha_steps [SEG_COUNT];
		alpha_steps = '{8'd0, 8'd1, 8'd0, 8'd128, 8'd254, 8'd255};
		arst_n           = 1'b0;
		cfg_we           = 1'b0;
		cfg_wdata        = '0;
		cmd_if.valid     = 1'b0;
		cmd_if.operation = OP_CLEAR;
		cmd_if.position  = '0;
		cmd_if.stop_rgb  = '0;
		ramp_if.ready    = 1'b0;
		src_idle_pct     = 11;
		sink_idle_pct    = 82;
		stop_cnt         = '0;
		alpha_q          = ALPHA_RESET;
		for (int i = 0; i < STOP_CAP; i++) begin
			stop_ofs[i] = '0;
			stop_col[i] = '0;
		end

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed table at reset alpha
		foreach (dir_rows[r])
			send_word(dir_rows[r].op, dir_rows[r].pos, dir_rows[r].rgb,
				dir_rows[r].fixed, dir_rows[r].fixed_px);
		drain();

		// random phases; idle pattern changes every two segments
		for (int seg = 0; seg < SEG_COUNT; seg++) begin
			src_idle_pct  = (seg < 2) ? 11 : (seg < 4) ? 82 : 0;
			sink_idle_pct = (seg < 2) ? 82 : (seg < 4) ? 11 : 0;
			write_alpha((seg == 2) ? 8'($urandom_range(253, 2)) : alpha_steps[seg]);
			if (seg == 0) begin
				// receiver holds off while lookups keep coming
				-> hold_start;
				repeat (12)
					send_word(OP_LOOKUP, 8'($urandom_range(255)), pick_rgb(), 1'b0, 32'h0);
			end
			run_segment(SEG_ITEMS);
			drain();
		end

		if (fail_count == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule
